FILE: rtl/fir_iir_direct_form_filter_core_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef FIR_IIR_DIRECT_FORM_FILTER_CORE_ASSERT_SVH
`define FIR_IIR_DIRECT_FORM_FILTER_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define FIIR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define FIIR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// expr never holds
`define FIIR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

FILE: rtl/fiir_pkg.sv
// Shared constants and types of the direct form I filter.
package fiir_pkg;

   localparam int MAX_TAPS_DEF   = 16;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 24;
   localparam int COEF_FRAC_BITS = 20;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;

   // one multiply-accumulate term traveling down the datapath
   typedef struct packed {
      logic vld;
      logic sub;
   } mac_ctl_type;

   // rounded and clipped sum
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] value;
      logic                   sat;
   } mac_res_type;

endpackage

FILE: rtl/fiir_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module fiir_ram import fiir_pkg::*; #(
   parameter int WIDTH = SAMPLE_BITS,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [2**AW];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fiir_mac.sv
// Shared multiply-accumulate datapath with rounding and saturation.
module fiir_mac import fiir_pkg::*; #(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          acc_clr,
   input  mac_ctl_type                   issue,
   input  logic signed [COEF_BITS-1:0]   coef,
   input  logic signed [SAMPLE_BITS-1:0] hist,
   output logic                          busy,
   output mac_res_type                   res
);

   // up to 2*MAX_TAPS products summed exactly
   localparam int ACC_W = PROD_BITS + $clog2(MAX_TAPS) + 1;

   mac_ctl_type                 s1_ff, s2_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic        [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W:0]       rnd_sum, rnd_q;
   logic                        in_range;

   assign prod_in  = coef * hist;
   assign prod_ext = {{(ACC_W-PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (acc_clr) begin
         acc_in = '0;
      end else if (s2_ff.vld) begin
         if (s2_ff.sub) begin
            acc_in = acc_ff - prod_ext;
         end else begin
            acc_in = acc_ff + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
      end
      if (s1_ff.vld) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign busy = s1_ff.vld | s2_ff.vld;

   // round half up: add half, then floor
   assign rnd_sum  = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(1 << (COEF_FRAC_BITS - 1));
   assign rnd_q    = rnd_sum >>> COEF_FRAC_BITS;
   assign in_range = (&rnd_q[ACC_W:SAMPLE_BITS-1]) | ~(|rnd_q[ACC_W:SAMPLE_BITS-1]);

   always_comb begin
      res.sat = ~in_range;
      if (in_range) begin
         res.value = rnd_q[SAMPLE_BITS-1:0];
      end else if (rnd_q[ACC_W]) begin
         res.value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res.value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

endmodule

FILE: rtl/fir_iir_direct_form_filter_core.sv
// Top level of the direct form I FIR/IIR filter: control, memories and result register.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+---------------------------
//   req     | action, coef_index, coef/smp  | valid / stall (block drives stall)
//   rsp     | filtered, saturated           | valid / stall (sink drives stall)
//   csr     | index, data                   | valid / ready (always ready)
//
// A sample item issues T terms, T = ff taps + (IIR ? fb taps - 1 : 0), at most 31
// at 16 taps, in turn through the one shared multiplier and one read port per memory.
// A coefficient write lands in the cycle it is taken; a clear fills every history entry.
// After reset a clear pass zeroes both memories; req is stalled meanwhile.
// A finished result waits in the output register; the next item is taken meanwhile,
// and a following sample stalls in its drain state until that register frees.
`include "fir_iir_direct_form_filter_core_assert.svh"

module fir_iir_direct_form_filter_core import fiir_pkg::*; #(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [3:0]                    req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_value,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [4:0]                    csr_data
);

   localparam int IW = $clog2(MAX_TAPS);
   localparam int AW = IW + 1;
   localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;

   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_WR_FF  = 2'd1;
   localparam logic [1:0] ACT_WR_FB  = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] CSR_IIR_MODE = 2'd0;
   localparam logic [1:0] CSR_FF_TAPS  = 2'd1;
   localparam logic [1:0] CSR_FB_TAPS  = 2'd2;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] a);
      logic [IW-1:0] r;
      if (a == IW'(MAX_TAPS - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [IW-1:0] ptr_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[IW]) begin
         d = d + (IW+1)'(MAX_TAPS);
      end
      return d[IW-1:0];
   endfunction

   // configuration
   logic          iir_ff, iir_in;
   logic [4:0]    ffcnt_ff, ffcnt_in, fbcnt_ff, fbcnt_in;
   logic [CW-1:0] nff, nfb;

   // control
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] tap_ff, tap_in;
   logic          fbph_ff, fbph_in;
   logic [AW-1:0] swp_ff, swp_in;
   logic          swcoef_ff, swcoef_in;
   logic [SAMPLE_BITS-1:0] fill_ff, fill_in;
   logic [IW-1:0] ihead_ff, ihead_in, ohead_ff, ohead_in, onew;
   logic          req_acc, out_free, finish, acc_clr, last_tap;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_filt_ff;
   logic                   rsp_sat_ff;

   // memory ports
   logic                   coef_we, hist_we, issue_rd;
   logic [AW-1:0]          coef_waddr, hist_waddr, coef_raddr, hist_raddr;
   logic [COEF_BITS-1:0]   coef_wdata, coef_rdata;
   logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;
   logic                   idx_ok;

   mac_ctl_type issue;
   mac_res_type mac_res;
   logic        mac_busy;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign onew      = iir_ff ? ptr_inc(ohead_ff) : ohead_ff;
   assign idx_ok    = (int'(req_coef_index) < MAX_TAPS);

   always_comb begin
      nff = CW'(ffcnt_ff);
      if (nff == '0) begin
         nff = CW'(1);
      end else if (nff > CW'(MAX_TAPS)) begin
         nff = CW'(MAX_TAPS);
      end
      nfb = CW'(fbcnt_ff);
      if (nfb == '0) begin
         nfb = CW'(1);
      end else if (nfb > CW'(MAX_TAPS)) begin
         nfb = CW'(MAX_TAPS);
      end
   end

   always_comb begin
      iir_in   = iir_ff;
      ffcnt_in = ffcnt_ff;
      fbcnt_in = fbcnt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IIR_MODE: iir_in   = csr_data[0];
            CSR_FF_TAPS:  ffcnt_in = csr_data;
            CSR_FB_TAPS:  fbcnt_in = csr_data;
            default: ;
         endcase
      end
   end

   assign last_tap = fbph_ff ? (tap_ff == nfb - 1'b1) : (tap_ff == nff - 1'b1);

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      fbph_in   = fbph_ff;
      swp_in    = swp_ff;
      swcoef_in = swcoef_ff;
      fill_in   = fill_ff;
      ihead_in  = ihead_ff;
      ohead_in  = ohead_ff;
      finish    = 1'b0;
      acc_clr   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_action)
                  ACT_SAMPLE: begin
                     state_in = ST_ISSUE;
                     tap_in   = '0;
                     fbph_in  = 1'b0;
                     ihead_in = ptr_inc(ihead_ff);
                     acc_clr  = 1'b1;
                  end
                  ACT_CLEAR: begin
                     state_in = ST_CLEAR;
                     swp_in   = '0;
                     fill_in  = req_sample_value;
                  end
                  ACT_WR_FF, ACT_WR_FB: ;
               endcase
            end
         end
         ST_CLEAR: begin
            swp_in = swp_ff + 1'b1;
            if (swp_ff == '1) begin
               state_in  = ST_IDLE;
               swcoef_in = 1'b0;
            end
         end
         ST_ISSUE: begin
            if (!last_tap) begin
               tap_in = tap_ff + 1'b1;
            end else if (!fbph_ff && iir_ff && nfb > CW'(1)) begin
               // feedback terms start at index 1; a0 is implied
               fbph_in = 1'b1;
               tap_in  = CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy && out_free) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
               ohead_in = onew;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iir_ff       <= 1'b0;
         ffcnt_ff     <= 5'd1;
         fbcnt_ff     <= 5'd1;
         state_ff     <= ST_CLEAR;
         tap_ff       <= '0;
         fbph_ff      <= 1'b0;
         swp_ff       <= '0;
         swcoef_ff    <= 1'b1;
         fill_ff      <= '0;
         ihead_ff     <= '0;
         ohead_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iir_ff       <= iir_in;
         ffcnt_ff     <= ffcnt_in;
         fbcnt_ff     <= fbcnt_in;
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         fbph_ff      <= fbph_in;
         swp_ff       <= swp_in;
         swcoef_ff    <= swcoef_in;
         fill_ff      <= fill_in;
         ihead_ff     <= ihead_in;
         ohead_ff     <= ohead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         rsp_filt_ff <= mac_res.value;
         rsp_sat_ff  <= mac_res.sat;
      end
   end

   assign rsp_valid_in  = finish | (rsp_valid_ff & rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filt_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Writes happen only in idle, clear and the final drain cycle, reads only while
   // issuing, so no read ever meets a pending write to the same entry.
   always_comb begin
      coef_we    = 1'b0;
      coef_waddr = {req_action == ACT_WR_FB, IW'(req_coef_index)};
      coef_wdata = req_coef_value;
      hist_we    = 1'b0;
      hist_waddr = {1'b0, ptr_inc(ihead_ff)};
      hist_wdata = req_sample_value;
      if (state_ff == ST_CLEAR) begin
         coef_we    = swcoef_ff;
         coef_waddr = swp_ff;
         coef_wdata = '0;
         hist_we    = 1'b1;
         hist_waddr = swp_ff;
         hist_wdata = fill_ff;
      end else if (finish) begin
         hist_we    = 1'b1;
         hist_waddr = {1'b1, onew};
         hist_wdata = mac_res.value;
      end else if (req_acc) begin
         coef_we = (req_action == ACT_WR_FF || req_action == ACT_WR_FB) && idx_ok;
         hist_we = (req_action == ACT_SAMPLE);
      end
   end

   assign issue_rd   = (state_ff == ST_ISSUE);
   assign issue.vld  = issue_rd;
   assign issue.sub  = fbph_ff;
   assign coef_raddr = {fbph_ff, tap_ff[IW-1:0]};
   assign hist_raddr = fbph_ff ? {1'b1, ptr_sub(ohead_ff, tap_ff[IW-1:0] - 1'b1)}
                               : {1'b0, ptr_sub(ihead_ff, tap_ff[IW-1:0])};

   fiir_ram #(.WIDTH(COEF_BITS), .AW(AW)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (issue_rd),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   fiir_ram #(.WIDTH(SAMPLE_BITS), .AW(AW)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (issue_rd),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   fiir_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
      .clock   (clock),
      .reset   (reset),
      .acc_clr (acc_clr),
      .issue   (issue),
      .coef    (signed'(coef_rdata)),
      .hist    (signed'(hist_rdata)),
      .busy    (mac_busy),
      .res     (mac_res)
   );

   `FIIR_ASSERT_NEVER(a_no_hist_wr_on_issue, clock, reset,
      hist_we && state_ff == ST_ISSUE, "history write during tap issue")
   `FIIR_ASSERT_NEVER(a_mac_idle_when_idle, clock, reset,
      state_ff == ST_IDLE && mac_busy, "datapath busy while idle")
   `FIIR_ASSERT_IMPL(a_tap_in_range, clock, reset, state_ff == ST_ISSUE,
      tap_ff < (fbph_ff ? nfb : nff), "tap index past tap count")
   `FIIR_ASSERT_NEXT(a_finish_loads_rsp, clock, reset,
      state_ff == ST_DRAIN && !mac_busy && out_free,
      rsp_valid_ff && state_ff == ST_IDLE, "finished item not loaded")

endmodule

FILE: test/fiir_tb_pkg.sv
// Item and register codes shared by the filter testbench files.
package fiir_tb_pkg;

   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_FF_COEF = 2'd1,
      ACT_FB_COEF = 2'd2,
      ACT_CLEAR   = 2'd3
   } filt_action_type;

   typedef enum logic [1:0] {
      REG_IIR_MODE = 2'd0,
      REG_FF_TAPS  = 2'd1,
      REG_FB_TAPS  = 2'd2,
      REG_UNUSED   = 2'd3
   } filt_reg_type;

endpackage

FILE: test/fiir_filter_checker.sv
// Filter output predictor and comparator, watching the req, rsp and csr channels.
module fiir_filter_checker import fiir_pkg::*; import fiir_tb_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [3:0]                    req_coef_index,
   input  logic signed [COEF_BITS-1:0]   req_coef_value,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   input  logic                          rsp_saturated,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [4:0]                    csr_data,
   output int                            error_count,
   output int                            results_pending
);

   localparam int     TAPS  = MAX_TAPS_DEF;
   localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint Y_MIN = -Y_MAX - 1;

   logic                          iir_on;
   logic [4:0]                    ff_taps;
   logic [4:0]                    fb_taps;
   logic signed [COEF_BITS-1:0]   ff_coef [TAPS];
   logic signed [COEF_BITS-1:0]   fb_coef [TAPS];
   logic signed [SAMPLE_BITS-1:0] x_hist [TAPS];
   logic signed [SAMPLE_BITS-1:0] y_hist [TAPS];
   mac_res_type                   filtered_q [$];
   int                            fails = 0;

   assign error_count     = fails;
   assign results_pending = filtered_q.size();

   function automatic int used_taps(logic [4:0] n);
      if (n == 0)
         return 1;
      if (n > TAPS)
         return TAPS;
      return n;
   endfunction

   always @(posedge clock) begin : track_filter
      mac_res_type want;
      mac_res_type got;
      longint      acc;
      longint      y;
      int          k;
      if (reset) begin
         iir_on  = 1'b0;
         ff_taps = 5'd1;
         fb_taps = 5'd1;
         for (k = 0; k < TAPS; k++) begin
            ff_coef[k] = '0;
            fb_coef[k] = '0;
            x_hist[k]  = '0;
            y_hist[k]  = '0;
         end
         filtered_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IIR_MODE: iir_on  = csr_data[0];
               REG_FF_TAPS:  ff_taps = csr_data;
               REG_FB_TAPS:  fb_taps = csr_data;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got.value = rsp_filtered;
            got.sat   = rsp_saturated;
            if (filtered_q.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result: filtered %0d saturated %0b",
                           $signed(got.value), got.sat);
            end else begin
               want = filtered_q.pop_front();
               if (got.value !== want.value || got.sat !== want.sat) begin
                  fails++;
                  if (fails <= 10)
                     $display({"result mismatch: filtered exp %0d got %0d, ",
                               "saturated exp %0b got %0b"},
                              $signed(want.value), $signed(got.value), want.sat, got.sat);
               end
            end
         end

         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_FF_COEF: ff_coef[req_coef_index] = req_coef_value;
               ACT_FB_COEF: fb_coef[req_coef_index] = req_coef_value;
               ACT_CLEAR: begin
                  for (k = 0; k < TAPS; k++) begin
                     x_hist[k] = req_sample_value;
                     y_hist[k] = req_sample_value;
                  end
               end
               default: begin
                  for (k = TAPS - 1; k > 0; k--)
                     x_hist[k] = x_hist[k-1];
                  x_hist[0] = req_sample_value;
                  // FIR mode leaves the output history in place, only its head is replaced
                  if (iir_on) begin
                     for (k = TAPS - 1; k > 0; k--)
                        y_hist[k] = y_hist[k-1];
                  end
                  acc = 0;
                  for (k = 0; k < used_taps(ff_taps); k++)
                     acc += longint'(ff_coef[k]) * longint'(x_hist[k]);
                  // a0 is normalized to one, feedback starts at tap 1
                  if (iir_on) begin
                     for (k = 1; k < used_taps(fb_taps); k++)
                        acc -= longint'(fb_coef[k]) * longint'(y_hist[k]);
                  end
                  y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
                  want.sat = 1'b1;
                  if (y > Y_MAX)
                     y = Y_MAX;
                  else if (y < Y_MIN)
                     y = Y_MIN;
                  else
                     want.sat = 1'b0;
                  want.value = y[SAMPLE_BITS-1:0];
                  y_hist[0]  = want.value;
                  filtered_q = {filtered_q, want};
               end
            endcase
         end
      end
   end

endmodule

FILE: test/fir_iir_direct_form_filter_core_tb.sv
// Stimulus, pacing and verdict for the direct form I filter core.
module fir_iir_direct_form_filter_core_tb;
   import fiir_pkg::*;
   import fiir_tb_pkg::*;

   localparam int SETTLE_CYCLES = 48;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 14;
   localparam int STREAM_ITEMS  = 95;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_action       = '0;
   logic [3:0]                    req_coef_index   = '0;
   logic signed [COEF_BITS-1:0]   req_coef_value   = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered;
   logic                          rsp_saturated;
   logic                          csr_valid        = 1'b0;
   logic                          csr_ready;
   logic [1:0]                    csr_index        = '0;
   logic [4:0]                    csr_data         = '0;

   int error_count;
   int results_pending;
   int cycle_count   = 0;
   int holds_asked   = 0;
   int holds_granted = 0;
   int burst_left    = 0;
   bit sender_eager  = 1'b0;

   fir_iir_direct_form_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   fiir_filter_checker filter_watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .results_pending  (results_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("fir_iir_direct_form_filter_core_tb: done, errors");
         $finish;
      end
   end

   // sink pacing: phases of no stall, heavy, light and periodic stall, plus long hold-offs
   initial begin : sink_pacing
      int style;
      int left;
      int tick;
      style = 0;
      left  = 0;
      tick  = 0;
      forever begin
         @(posedge clock);
         if (holds_granted != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_granted++;
         end else begin
            if (left == 0) begin
               style = $urandom_range(0, 3);
               left  = $urandom_range(16, 160);
            end
            left--;
            tick++;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(0, 1);
               2: rsp_stall <= ($urandom_range(0, 7) == 0);
               default: rsp_stall <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   function automatic logic signed [COEF_BITS-1:0] rand_coef(int shift);
      logic signed [COEF_BITS-1:0] c;
      c = COEF_BITS'($urandom);
      return c >>> shift;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      logic signed [SAMPLE_BITS-1:0] s;
      s = SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 11))
         0: s = 16'sh7fff;
         1: s = 16'sh8000;
         default: s = s >>> $urandom_range(0, 8);
      endcase
      return s;
   endfunction

   // present one item, hold it until taken, then maybe close the burst with a gap
   task automatic offer_item(filt_action_type act, logic [3:0] idx,
                             logic signed [COEF_BITS-1:0] coef,
                             logic signed [SAMPLE_BITS-1:0] smp);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_coef_index   <= idx;
      req_coef_value   <= coef;
      req_sample_value <= smp;
      do
         @(posedge clock);
      while (req_stall);
      if (!sender_eager) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic offer_sample(logic signed [SAMPLE_BITS-1:0] smp);
      offer_item(ACT_SAMPLE, 4'($urandom), COEF_BITS'($urandom), smp);
   endtask

   task automatic offer_coef(filt_action_type act, logic [3:0] idx,
                             logic signed [COEF_BITS-1:0] coef);
      offer_item(act, idx, coef, SAMPLE_BITS'($urandom));
   endtask

   task automatic offer_clear(logic signed [SAMPLE_BITS-1:0] fill);
      offer_item(ACT_CLEAR, 4'($urandom), COEF_BITS'($urandom), fill);
   endtask

   // drain all results, then let a trailing clear or coefficient write finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_filter(logic [4:0] mode_word, logic [4:0] ff_word,
                                 logic [4:0] fb_word, bit touch_unused);
      filt_reg_type regs [4];
      logic [4:0]   words [4];
      int           n;
      int           k;
      regs  = '{REG_IIR_MODE, REG_FF_TAPS, REG_FB_TAPS, REG_UNUSED};
      words = '{mode_word, ff_word, fb_word, 5'($urandom)};
      n = touch_unused ? 4 : 3;
      for (k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_data  <= words[k];
         do
            @(posedge clock);
         while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [4:0] pick_taps();
      case ($urandom_range(0, 6))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(2, 15));
      endcase
   endfunction

   initial begin : stimulus
      int         ph;
      int         n;
      int         k;
      int         shift;
      int         pick;
      logic [4:0] mode_word;
      logic [4:0] ff_word;
      logic [4:0] fb_word;
      int         shifts [4];
      shifts = '{0, 6, 9, 11};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // FIR with a count of zero (acts as one) and an oversized feedback count
      program_filter(5'b00000, 5'd0, 5'd31, 1'b1);
      offer_coef(ACT_FF_COEF, 4'd0, 24'sh7fffff);
      offer_coef(ACT_FB_COEF, 4'd0, 24'sh800000);
      offer_sample(16'sh7fff);
      offer_sample(16'sh8000);
      offer_sample(16'sh0000);
      offer_coef(ACT_FF_COEF, 4'd15, 24'sh800000);
      offer_coef(ACT_FB_COEF, 4'd15, 24'sh7fffff);
      offer_clear(16'sh8000);
      offer_sample(16'sh0001);
      wait_idle();

      // IIR, feed-forward count above the tap limit, feedback count of zero
      program_filter(5'b11111, 5'd31, 5'd0, 1'b1);
      offer_sample(16'sh7fff);
      offer_clear(16'sh7fff);
      offer_sample(-16'sd1);
      wait_idle();

      // half-valued taps give rounding ties in both directions
      program_filter(5'b00001, 5'd2, 5'd16, 1'b0);
      offer_coef(ACT_FF_COEF, 4'd1, 24'sh080000);
      offer_coef(ACT_FB_COEF, 4'd1, 24'sh080000);
      offer_coef(ACT_FF_COEF, 4'd0, 24'sh100000);
      offer_sample(16'sd3);
      offer_sample(-16'sd3);
      offer_sample(16'sd1);
      offer_clear(16'sh0000);
      offer_sample(16'sh8000);
      wait_idle();

      // FIR only overwrites the newest output, seen once IIR is back on
      program_filter(5'b00000, 5'd16, 5'd1, 1'b0);
      offer_sample(16'sd12345);
      offer_sample(-16'sd12345);
      wait_idle();

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin mode_word = 5'd1; ff_word = 5'd16; fb_word = 5'd16; end
            1: begin mode_word = 5'd0; ff_word = 5'd16; fb_word = pick_taps(); end
            2: begin mode_word = 5'd1; ff_word = 5'd1;  fb_word = 5'd1;  end
            3: begin mode_word = 5'd1; ff_word = 5'd0;  fb_word = 5'd31; end
            default: begin
               mode_word = {4'($urandom), 1'($urandom)};
               ff_word   = pick_taps();
               fb_word   = pick_taps();
            end
         endcase
         wait_idle();
         program_filter(mode_word, ff_word, fb_word, $urandom_range(0, 3) == 0);
         shift = shifts[$urandom_range(0, 3)];
         // stable IIR needs small feedback taps most of the time
         if (mode_word[0] && $urandom_range(0, 3) != 0 && shift < 9)
            shift = 9;
         sender_eager = (ph == 2 || ph == 9 || $urandom_range(0, 5) == 0);

         for (k = 0; k < MAX_TAPS_DEF; k++) begin
            offer_coef(ACT_FF_COEF, 4'(k), rand_coef(shift));
            offer_coef(ACT_FB_COEF, 4'(k), rand_coef(shift));
         end
         if ($urandom_range(0, 1) == 1)
            offer_clear(rand_sample());

         // the sink holds off while samples keep coming, so the core backs up
         if (ph == 2 || ph == 9)
            holds_asked++;

         for (n = 0; n < STREAM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 86)
               offer_sample(rand_sample());
            else if (pick < 92)
               offer_coef(ACT_FF_COEF, 4'($urandom), rand_coef(shift));
            else if (pick < 96)
               offer_coef(ACT_FB_COEF, 4'($urandom), rand_coef(shift));
            else if (pick < 98)
               offer_clear(rand_sample());
            else
               offer_coef(ACT_FF_COEF, 4'($urandom), rand_coef(0));
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("fir_iir_direct_form_filter_core_tb: done, clean");
      else
         $display("fir_iir_direct_form_filter_core_tb: done, errors");
      $finish;
   end

endmodule

FILE: fir_iir_direct_form_filter_core.f
+incdir+rtl
rtl/fiir_pkg.sv
rtl/fiir_ram.sv
rtl/fiir_mac.sv
rtl/fir_iir_direct_form_filter_core.sv
test/fiir_tb_pkg.sv
test/fiir_filter_checker.sv
test/fir_iir_direct_form_filter_core_tb.sv
